@@ rtl/e2hp_pkg.sv @@
// Package for the Euler-to-pose block: widths, the CORDIC arctangent table
// and small fixed-point helpers. No dependencies.
`default_nettype none
package e2hp_pkg;
  localparam int CordicSteps = 16;
  localparam int FracBits = 16;
  localparam int OutFrac = 16;
  localparam int VW = FracBits + 4;      // CORDIC x/y width
  localparam int ZW = 34;                // Q8.24 angle accumulator plus headroom
  localparam logic signed [33:0] DegFull = 34'sd23592960;
  localparam logic signed [33:0] DegHalf = 34'sd11796480;
  localparam logic signed [33:0] DegQuarter = 34'sd5898240;
  localparam longint GainQ30 = 64'd652032874;
  localparam logic signed [VW-1:0] Gain =
    VW'((GainQ30 + (64'd1 << (30 - FracBits - 1))) >> (30 - FracBits));

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
  } rot_t;

  function automatic ang_t atan_q24(input logic [4:0] i);
    case (i)
      5'd0:  atan_q24 = ZW'(754974720);
      5'd1:  atan_q24 = ZW'(445687602);
      5'd2:  atan_q24 = ZW'(235489088);
      5'd3:  atan_q24 = ZW'(119537938);
      5'd4:  atan_q24 = ZW'(60000934);
      5'd5:  atan_q24 = ZW'(30029717);
      5'd6:  atan_q24 = ZW'(15018523);
      5'd7:  atan_q24 = ZW'(7509720);
      5'd8:  atan_q24 = ZW'(3754917);
      5'd9:  atan_q24 = ZW'(1877466);
      5'd10: atan_q24 = ZW'(938734);
      5'd11: atan_q24 = ZW'(469367);
      5'd12: atan_q24 = ZW'(234684);
      5'd13: atan_q24 = ZW'(117342);
      5'd14: atan_q24 = ZW'(58671);
      5'd15: atan_q24 = ZW'(29335);
      5'd16: atan_q24 = ZW'(14668);
      5'd17: atan_q24 = ZW'(7334);
      5'd18: atan_q24 = ZW'(3667);
      5'd19: atan_q24 = ZW'(1833);
      5'd20: atan_q24 = ZW'(917);
      5'd21: atan_q24 = ZW'(458);
      5'd22: atan_q24 = ZW'(229);
      5'd23: atan_q24 = ZW'(115);
      default: atan_q24 = '0;
    endcase
  endfunction

  // Rounded fixed-point product, half an LSB added then arithmetic shift.
  function automatic vec_t fmul(input vec_t a, input vec_t b);
    logic signed [2*VW-1:0] p;
    p = a * b + (2*VW)'(64'sd1 <<< (FracBits - 1));
    fmul = VW'(p >>> FracBits);
  endfunction

  // Rescale to 16 fraction bits and saturate to plus or minus one.
  function automatic logic signed [17:0] to_out(input vec_t v);
    logic signed [VW+8:0] o;
    if (FracBits > OutFrac)
      o = (VW+9)'((v + (VW'(1) <<< (FracBits - OutFrac - 1))) >>> (FracBits - OutFrac));
    else
      o = (VW+9)'(v) <<< (OutFrac - FracBits);
    if (o > 65536) to_out = 18'sd65536;
    else if (o < -65536) to_out = -18'sd65536;
    else to_out = 18'(o);
  endfunction
endpackage
`default_nettype wire

@@ rtl/e2hp_cell.sv @@
// One CORDIC micro-rotation cell for the three angles of a pose.
// Depends on e2hp_pkg.
`default_nettype none
module e2hp_cell
  import e2hp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [4:0] step,
  input  wire rot_t       din [3],
  output rot_t            dout [3]
);
  rot_t nxt [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!din[k].z[ZW-1]) begin
        nxt[k].x = din[k].x - (din[k].y >>> step);
        nxt[k].y = din[k].y + (din[k].x >>> step);
        nxt[k].z = din[k].z - atan_q24(step);
      end else begin
        nxt[k].x = din[k].x + (din[k].y >>> step);
        nxt[k].y = din[k].y - (din[k].x >>> step);
        nxt[k].z = din[k].z + atan_q24(step);
      end
    end
  end
  always_ff @(posedge clk) begin
    dout <= nxt;
  end
endmodule
`default_nettype wire

@@ rtl/euler_to_homogeneous_pose.sv @@
// Top level of the Euler ZYX to homogeneous pose block.
// Depends on e2hp_pkg and e2hp_cell.
//
// A pose beat is taken at each rising edge with start high; busy is tied
// low, so a new pose may enter every cycle and throughput is one pose per
// clock. The first stage wraps each angle into one turn: the Q16.16 angle
// splits into a count of 2^19 steps and a remainder, and since a full turn
// is 45 such steps only the count needs a small reduction modulo 45, done
// by a reciprocal multiplication. The second stage moves the wrapped angle
// into [-180, 180) and folds it into [-90, 90], noting a cosine sign flip.
// A row of identical CORDIC cells, one per iteration, then hands the x, y
// and angle words of all three angles down the chain once per cycle. Two
// product stages and an output stage follow. The result strobe done comes
// from a valid shift register that runs alongside these stages, and the
// beat is taken at the edge that ends the cycle in which done is high. The
// position words and the cosine sign flags travel alongside in shift
// registers. The receiver cannot stall, so no buffering is needed. Reset
// clears the valid chain only, so no stale result strobes after reset; the
// payload registers are not reset.
`default_nettype none
module euler_to_homogeneous_pose
  import e2hp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] roll_deg,
  input  wire logic signed [31:0] pitch_deg,
  input  wire logic signed [31:0] yaw_deg,
  output logic                    done,
  output logic signed [17:0]      m00,
  output logic signed [17:0]      m01,
  output logic signed [17:0]      m02,
  output logic signed [17:0]      m10,
  output logic signed [17:0]      m11,
  output logic signed [17:0]      m12,
  output logic signed [17:0]      m20,
  output logic signed [17:0]      m21,
  output logic signed [17:0]      m22,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z
);
  localparam int Lat = CordicSteps + 5;

  // A full turn is 45 steps of 2^19 in Q16.16 degrees. The step count is
  // biased by a multiple of 45 to make it non-negative, then divided by 45
  // through a reciprocal that is exact over the whole biased range.
  localparam logic [13:0] StepBias = 14'd4140;
  localparam logic [26:0] Recip45 = 27'd11651;
  localparam logic [13:0] TurnSteps = 14'd45;

  assign busy = 1'b0;

  // Floor modulo one turn, giving a value in [0, 360) degrees.
  function automatic logic [24:0] wrap_turn(input logic signed [31:0] a);
    logic [13:0] u;
    logic [26:0] prod;
    logic [7:0] q;
    logic [13:0] qd;
    logic [13:0] rem;
    u = {a[31], a[31:19]} + StepBias;
    prod = 27'(u) * Recip45;
    q = prod[26:19];
    qd = 14'(q) * TurnSteps;
    rem = u - qd;
    wrap_turn = {rem[5:0], a[18:0]};
  endfunction

  // Fold of one wrapped angle into [-90, 90] with a cosine flip flag.
  function automatic logic [34:0] reduce(input logic [24:0] w);
    logic signed [33:0] r;
    logic flip;
    r = signed'(34'(w));
    if (r >= DegHalf) r = r - DegFull;
    flip = 1'b0;
    if (r > DegQuarter) begin
      r = DegHalf - r;
      flip = 1'b1;
    end else if (r < -DegQuarter) begin
      r = -DegHalf - r;
      flip = 1'b1;
    end
    reduce = {flip, r};
  endfunction

  logic [24:0] turn [3];
  always_ff @(posedge clk) begin
    turn[0] <= wrap_turn(roll_deg);
    turn[1] <= wrap_turn(pitch_deg);
    turn[2] <= wrap_turn(yaw_deg);
  end

  logic [34:0] red [3];
  always_comb begin
    red[0] = reduce(turn[0]);
    red[1] = reduce(turn[1]);
    red[2] = reduce(turn[2]);
  end

  localparam int FI = CordicSteps;
  rot_t head [3];
  rot_t chain [CordicSteps+1][3];
  logic [2:0] flip_d [FI+1];
  logic [Lat-1:0] vld;
  logic signed [31:0] px_d [Lat-1];
  logic signed [31:0] py_d [Lat-1];
  logic signed [31:0] pz_d [Lat-1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      head[k].x <= Gain;
      head[k].y <= '0;
      head[k].z <= ZW'(signed'(red[k][33:0])) <<< 8;
    end
    flip_d[0] <= {red[2][34], red[1][34], red[0][34]};
    for (int s = 1; s < FI + 1; s++) begin
      flip_d[s] <= flip_d[s-1];
    end
    px_d[0] <= pos_x;
    py_d[0] <= pos_y;
    pz_d[0] <= pos_z;
    for (int s = 1; s < Lat - 1; s++) begin
      px_d[s] <= px_d[s-1];
      py_d[s] <= py_d[s-1];
      pz_d[s] <= pz_d[s-1];
    end
  end

  assign chain[0] = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Lat-2:0], start};
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    e2hp_cell u_cell (
      .clk (clk),
      .step(5'(g)),
      .din (chain[g]),
      .dout(chain[g+1])
    );
  end

  // Sines and cosines with the fold applied.
  vec_t sa, ca, sb, cb, sc, cc;
  always_comb begin
    sa = chain[CordicSteps][0].y;
    sb = chain[CordicSteps][1].y;
    sc = chain[CordicSteps][2].y;
    ca = flip_d[FI][0] ? -chain[CordicSteps][0].x : chain[CordicSteps][0].x;
    cb = flip_d[FI][1] ? -chain[CordicSteps][1].x : chain[CordicSteps][1].x;
    cc = flip_d[FI][2] ? -chain[CordicSteps][2].x : chain[CordicSteps][2].x;
  end

  // First product stage: all two-factor products.
  vec_t p_cbcc, p_ccsa, p_casc, p_sasc, p_cacc, p_cbsc, p_sasb, p_casb, p_ccsa2;
  vec_t p_cbsa, p_cacb, r_sb, r_sb2, r_sc, r_sc2;
  always_ff @(posedge clk) begin
    p_cbcc <= fmul(cb, cc);
    p_ccsa <= fmul(cc, sa);
    p_casc <= fmul(ca, sc);
    p_sasc <= fmul(sa, sc);
    p_cacc <= fmul(ca, cc);
    p_cbsc <= fmul(cb, sc);
    p_sasb <= fmul(sa, sb);
    p_casb <= fmul(ca, sb);
    p_ccsa2 <= fmul(cc, sa);
    p_cbsa <= fmul(cb, sa);
    p_cacb <= fmul(ca, cb);
    r_sb <= sb;
    r_sb2 <= sb;
    r_sc <= sc;
    r_sc2 <= sc;
  end

  // Second product stage: three-factor terms and sums.
  vec_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
  always_ff @(posedge clk) begin
    e00 <= p_cbcc;
    e01 <= fmul(p_ccsa, r_sb) - p_casc;
    e02 <= p_sasc + fmul(p_cacc, r_sb2);
    e10 <= p_cbsc;
    e11 <= p_cacc + fmul(p_sasb, r_sc);
    e12 <= fmul(p_casb, r_sc2) - p_ccsa2;
    e20 <= -r_sb;
    e21 <= p_cbsa;
    e22 <= p_cacb;
  end

  always_ff @(posedge clk) begin
    m00 <= to_out(e00);
    m01 <= to_out(e01);
    m02 <= to_out(e02);
    m10 <= to_out(e10);
    m11 <= to_out(e11);
    m12 <= to_out(e12);
    m20 <= to_out(e20);
    m21 <= to_out(e21);
    m22 <= to_out(e22);
    out_x <= px_d[Lat-2];
    out_y <= py_d[Lat-2];
    out_z <= pz_d[Lat-2];
  end

  assign done = vld[Lat-1];
endmodule
`default_nettype wire

@@ test/tb_euler_to_homogeneous_pose.sv @@
// Testbench for euler_to_homogeneous_pose: drives pose beats, predicts the
// rotation entries with a bit-accurate CORDIC model and checks each result.
// Depends on e2hp_pkg and the block's RTL.
`default_nettype none
module tb_euler_to_homogeneous_pose;
  import e2hp_pkg::*;

  // One full, half and quarter turn in Q16.16 degrees.
  localparam longint TurnFull = 64'sd23592960;
  localparam longint TurnHalf = 64'sd11796480;
  localparam longint TurnQuarter = 64'sd5898240;
  localparam int Latency = CordicSteps + 4;
  localparam longint CycleLimit = 200000;

  // Arctangent of 2^-i in Q8.24 degrees.
  localparam longint AtanDeg[24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  typedef struct {
    logic signed [17:0] m [9];
    logic signed [31:0] px, py, pz;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] roll_deg = '0, pitch_deg = '0, yaw_deg = '0;
  logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [31:0] out_x, out_y, out_z;

  pose_t expected_poses[$];
  int errors = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;

  always #4 clk = ~clk;

  euler_to_homogeneous_pose dut (
    .clk, .rst, .start, .busy, .pos_x, .pos_y, .pos_z, .roll_deg,
    .pitch_deg, .yaw_deg, .done, .m00, .m01, .m02, .m10, .m11, .m12,
    .m20, .m21, .m22, .out_x, .out_y, .out_z);

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v, int s);
    if (s <= 0) return v;
    return shr(v + (64'sd1 <<< (s - 1)), s);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_q(a * b, FracBits);
  endfunction

  // Angle reduction into [-90, 90] with a cosine sign flag, then CORDIC.
  task automatic angle_sin_cos(input logic signed [31:0] deg, output longint s,
                               output longint c);
    longint r, x, y, z, dx, dy;
    bit flip;
    int n;
    r = longint'(deg) % TurnFull;
    flip = 1'b0;
    if (r < 0) r += TurnFull;
    if (r >= TurnHalf) r -= TurnFull;
    if (r > TurnQuarter) begin
      r = TurnHalf - r;
      flip = 1'b1;
    end else if (r < -TurnQuarter) begin
      r = -TurnHalf - r;
      flip = 1'b1;
    end
    x = round_q(64'sd652032874, 30 - FracBits);
    y = 0;
    z = r * 256;
    n = (CordicSteps > 24) ? 24 : CordicSteps;
    for (int i = 0; i < n; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanDeg[i];
      end else begin
        x += dx; y -= dy; z += AtanDeg[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  function automatic logic signed [17:0] to_q1_16(longint v);
    longint o;
    if (FracBits >= 16) o = round_q(v, FracBits - 16);
    else o = v <<< (16 - FracBits);
    if (o > 65536) o = 65536;
    if (o < -65536) o = -65536;
    return 18'(o);
  endfunction

  task automatic predict_pose(input logic signed [31:0] x, y, z, r, p, w);
    pose_t e;
    longint sa, ca, sb, cb, sc, cc;
    angle_sin_cos(r, sa, ca);
    angle_sin_cos(p, sb, cb);
    angle_sin_cos(w, sc, cc);
    e.m[0] = to_q1_16(qmul(cb, cc));
    e.m[1] = to_q1_16(qmul(qmul(cc, sa), sb) - qmul(ca, sc));
    e.m[2] = to_q1_16(qmul(sa, sc) + qmul(qmul(ca, cc), sb));
    e.m[3] = to_q1_16(qmul(cb, sc));
    e.m[4] = to_q1_16(qmul(ca, cc) + qmul(qmul(sa, sb), sc));
    e.m[5] = to_q1_16(qmul(qmul(ca, sb), sc) - qmul(cc, sa));
    e.m[6] = to_q1_16(-sb);
    e.m[7] = to_q1_16(qmul(cb, sa));
    e.m[8] = to_q1_16(qmul(ca, cb));
    e.px = x; e.py = y; e.pz = z;
    expected_poses.push_back(e);
  endtask

  // Sends one pose beat; start is held over back-to-back beats and only
  // dropped for random idle cycles.
  task automatic send_pose(input logic signed [31:0] x, y, z, r, p, w);
    while (!no_idle && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= x; pos_y <= y; pos_z <= z;
    roll_deg <= r; pitch_deg <= p; yaw_deg <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_pose(x, y, z, r, p, w);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] deg(int d);
    return 32'(d * 65536);
  endfunction

  // Random angle: mostly within one turn either side of zero, sometimes full
  // range or at or near a multiple of ninety degrees where the folding edges lie.
  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(3))
      0: return 32'($urandom);
      1: return deg(90 * ($urandom_range(16) - 8)) + 32'($urandom_range(4) - 2);
      default: return 32'($urandom_range(2 * 23592960) - 23592960);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [31:0] minv, maxv;
    minv = 32'sh80000000;
    maxv = 32'sh7fffffff;
    send_pose(maxv, minv, 0, 0, 0, 0);
    send_pose(minv, maxv, -1, maxv, maxv, maxv);
    send_pose(0, 0, maxv, minv, minv, minv);
    send_pose(1, -1, 0, -1, 1, -1);
  endtask

  task automatic test_quadrant_edges();
    // Exactly -180 degrees folds to zero with a negated cosine.
    send_pose(0, 0, 0, deg(-180), deg(-180), deg(-180));
    send_pose(0, 0, 0, deg(180), deg(90), deg(-90));
    send_pose(0, 0, 0, deg(90) + 1, deg(90) - 1, deg(-90) - 1);
    send_pose(0, 0, 0, deg(270), deg(-270), deg(360));
    send_pose(0, 0, 0, deg(360) - 1, deg(-360), deg(720) + 1);
    // Near-zero pitch and yaw push the gain error past one; saturation clips.
    send_pose(0, 0, 0, deg(45), 0, 0);
    send_pose(0, 0, 0, deg(30), deg(60), deg(-120));
    send_pose(0, 0, 0, deg(135), deg(-45), deg(225));
  endtask

  task automatic test_random_poses(int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3 && i < count / 2);
      send_pose(32'($urandom), 32'($urandom), 32'($urandom),
                rand_angle(), rand_angle(), rand_angle());
    end
    no_idle = 1'b0;
  endtask

  task automatic check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      errors++;
    end
  endtask

  // Result checker: the receiver cannot stall, so every done beat is taken.
  always @(posedge clk) begin
    pose_t e;
    if (!rst && done) begin
      if (expected_poses.size() == 0) begin
        $error("result beat with no pose outstanding");
        errors++;
      end else begin
        e = expected_poses.pop_front();
        check_field("m00", e.m[0], m00);
        check_field("m01", e.m[1], m01);
        check_field("m02", e.m[2], m02);
        check_field("m10", e.m[3], m10);
        check_field("m11", e.m[4], m11);
        check_field("m12", e.m[5], m12);
        check_field("m20", e.m[6], m20);
        check_field("m21", e.m[7], m21);
        check_field("m22", e.m[8], m22);
        check_field("out_x", e.px, out_x);
        check_field("out_y", e.py, out_y);
        check_field("out_z", e.pz, out_z);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_quadrant_edges();
    test_random_poses(1240);
    release_start();
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/e2hp_pkg.sv
rtl/e2hp_cell.sv
rtl/euler_to_homogeneous_pose.sv
test/tb_euler_to_homogeneous_pose.sv
